/* design/qips_pkg.sv */
// ----------------------------------------------------------------------------
// qips_pkg: shared types and codes for the ordered insert/pop/search queue
// Holds action and status codes, the value type and the per-cell command.
// ----------------------------------------------------------------------------
package qips_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    localparam int VAL_W = 32;

    typedef logic signed [VAL_W-1:0] value_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic pop;
        logic srch;
    } cell_cmd_t;

endpackage

/* design/qips_cell.sv */
// ----------------------------------------------------------------------------
// qips_cell: one storage slot of the queue row
// Holds one entry, shifts toward the tail on insert and toward the head on
// pop, and compares its entry against the search value.
// ----------------------------------------------------------------------------
module qips_cell #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  qips_pkg::cell_cmd_t cmd,
    input  logic [IDX_W-1:0]    slot,
    input  qips_pkg::value_t    ins_value,
    input  qips_pkg::value_t    left_value,
    input  qips_pkg::value_t    right_value,
    input  logic                valid,
    output qips_pkg::value_t    value,
    output logic                hit
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    qips_pkg::value_t value_reg;
    qips_pkg::value_t value_next;
    logic             hit_reg;
    logic             hit_next;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (MY_IDX > slot)
                value_next = left_value;
            else if (MY_IDX == slot)
                value_next = ins_value;
        end
        else if (cmd.pop)
        begin
            value_next = right_value;
        end
        hit_next = cmd.srch && valid && (value_reg == ins_value);
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else
            hit_reg <= hit_next;
    end

    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

/* design/queue_insert_pop_search.sv */
// A result strobes on done after the item passes the v1 and done registers.
// Throughput: one item per cycle once busy is low; the cell row registers the
// update and the search hit bits, which a registered OR then merges.
// Reset: the entry count clears at once, entries are undefined until written;
// busy is held high by reset and clears once the clock runs after release.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
// queue_insert_pop_search: bounded ordered queue with insert, pop and search
// A row of cells holds the entries head first; control broadcasts the action.
// ----------------------------------------------------------------------------
module queue_insert_pop_search #(
    parameter int DEPTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             action,
    input  logic signed [31:0]     value,
    input  logic signed [5:0]      position,
    output logic                   done,
    output logic [1:0]             status,
    output logic signed [31:0]     popped_value,
    output logic                   found,
    output logic [4:0]             count,
    output logic                   is_empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic                 busy_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    // first result stage
    logic                 v1_reg;
    logic [1:0]           status1_reg;
    logic [1:0]           status1_next;
    qips_pkg::value_t     popped1_reg;
    qips_pkg::value_t     popped1_next;
    logic [CNT_W-1:0]     count1_reg;

    // output stage
    logic                 done_reg;
    logic [1:0]           status_reg;
    qips_pkg::value_t     popped_reg;
    logic                 found_reg;
    logic [4:0]           count_out_reg;
    logic                 empty_reg;

    logic                 accept;
    qips_pkg::cell_cmd_t  cmd;
    logic [IDX_W-1:0]     slot;
    logic [CNT_W+4:0]     pos_ext;
    logic [CNT_W+4:0]     cnt_ext;
    logic [CNT_W+4:0]     cnt1_ext;
    logic                 full;
    logic                 empty;

    qips_pkg::value_t     cell_val   [DEPTH];
    qips_pkg::value_t     left_val   [DEPTH];
    qips_pkg::value_t     right_val  [DEPTH];
    logic [DEPTH-1:0]     hits;

    assign accept  = start && !busy_reg;
    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign pos_ext = {{CNT_W{1'b0}}, position[4:0]};
    assign cnt_ext = {5'b0, count_reg};

    always_comb
    begin
        // negative or past-the-tail positions append
        if (!position[5] && (pos_ext < cnt_ext))
            slot = pos_ext[IDX_W-1:0];
        else
            slot = count_reg[IDX_W-1:0];

        cmd          = '0;
        count_next   = count_reg;
        status1_next = qips_pkg::ST_OK;
        popped1_next = '0;
        if (accept)
        begin
            case (action)
                qips_pkg::ACT_INSERT:
                begin
                    if (full)
                        status1_next = qips_pkg::ST_FULL;
                    else
                    begin
                        cmd.ins    = 1'b1;
                        count_next = count_reg + CNT_ONE;
                    end
                end
                qips_pkg::ACT_POP:
                begin
                    if (empty)
                        status1_next = qips_pkg::ST_EMPTY;
                    else
                    begin
                        cmd.pop      = 1'b1;
                        popped1_next = cell_val[0];
                        count_next   = count_reg - CNT_ONE;
                    end
                end
                qips_pkg::ACT_SEARCH:
                    cmd.srch = 1'b1;
                default:
                    cmd = '0;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign left_val[gi] = value;
            end
            else
            begin : g_mid
                assign left_val[gi] = cell_val[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_val[gi] = cell_val[gi];
            end
            else
            begin : g_next
                assign right_val[gi] = cell_val[gi+1];
            end

            qips_cell #(
                .IDX_W (IDX_W),
                .IDX   (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .slot        (slot),
                .ins_value   (value),
                .left_value  (left_val[gi]),
                .right_value (right_val[gi]),
                .valid       (CNT_W'(gi) < count_reg),
                .value       (cell_val[gi]),
                .hit         (hits[gi])
            );
        end
    endgenerate

    assign cnt1_ext = {5'b0, count1_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
            v1_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= 1'b0;
            count_reg <= count_next;
            v1_reg    <= accept;
            done_reg  <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        status1_reg   <= status1_next;
        popped1_reg   <= popped1_next;
        count1_reg    <= count_next;
        status_reg    <= status1_reg;
        popped_reg    <= popped1_reg;
        found_reg     <= |hits;
        count_out_reg <= cnt1_ext[4:0];
        empty_reg     <= (count1_reg == '0);
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign found        = found_reg;
    assign count        = count_out_reg;
    assign is_empty     = empty_reg;

endmodule

/* design/qips_checker.sv */
// ----------------------------------------------------------------------------
// qips_checker: port-level checks for the ordered queue
// Watches the command and result ports and flags timing and status slips.
// ----------------------------------------------------------------------------
module qips_checker #(
    parameter int DEPTH = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [1:0]         status,
    input logic signed [31:0] popped_value,
    input logic               found,
    input logic [4:0]         count,
    input logic               is_empty
);

    localparam logic [4:0] FULL_LOW = 5'(DEPTH);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted item produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an accepted item");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == qips_pkg::ST_FULL) |-> (count == FULL_LOW && !is_empty))
        else $error("full refusal with wrong count");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == qips_pkg::ST_EMPTY) |->
            (is_empty && count == 5'd0 && popped_value == 32'sd0 && !found))
        else $error("empty refusal with wrong fields");

    a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == qips_pkg::ST_OK && !is_empty))
        else $error("search hit on an empty queue");

endmodule

bind queue_insert_pop_search qips_checker #(
    .DEPTH (DEPTH)
) u_qips_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .popped_value (popped_value),
    .found        (found),
    .count        (count),
    .is_empty     (is_empty)
);
